[src/rtpsbc_pkg.sv]
// Shared types and constants of the RTP / A2DP SBC payload locator.
package rtpsbc_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned COUNT_W  = 16;
   localparam int unsigned EXT_W    = 16;
   localparam int unsigned POS_W    = 19;
   localparam int unsigned BASE_W   = 7;
   localparam int unsigned SIZE_W   = 17;
   localparam int unsigned CODE_W   = 4;
   localparam int unsigned FRAMES_W = 4;

   // Fixed RTP header length and the shortest packet that can hold the SBC media header.
   localparam logic [BASE_W-1:0] RTP_FIXED_LEN = 7'd12;
   localparam logic [SIZE_W-1:0] RTP_MIN_LEN   = 17'd13;
   localparam logic [POS_W-1:0]  EXT_HDR_LEN   = 19'd4;
   localparam logic [1:0]        HDR_VER_EXPECTED = 2'b10;

   // Bit positions inside the first RTP header byte.
   localparam int unsigned HDR_PAD_BIT = 5;
   localparam int unsigned HDR_EXT_BIT = 4;

   typedef enum logic [CODE_W-1:0] {
      ERR_NONE          = 4'd0,
      ERR_SHORT         = 4'd1,
      ERR_VERSION       = 4'd2,
      ERR_CSRC_OVERRUN  = 4'd3,
      ERR_EXT_TRUNCATED = 4'd4,
      ERR_EXT_OVERRUN   = 4'd5,
      ERR_PADDING       = 4'd6,
      ERR_NO_SBC_HEADER = 4'd7,
      ERR_ZERO_FRAMES   = 4'd8,
      ERR_EMPTY_PAYLOAD = 4'd9,
      ERR_TOO_LONG      = 4'd10
   } err_code_type;

   // What the tracker knows about the packet once the current beat is applied.
   typedef struct packed {
      logic [COUNT_W-1:0] byte_index;
      logic               overlength;
      logic [BYTE_W-1:0]  header_first;
      logic [POS_W-1:0]   media_pos;
      logic [BYTE_W-1:0]  media_hdr;
   } pkt_view_type;

   // Offset of the extension header (or of the media header without one).
   function automatic logic [BASE_W-1:0] csrc_end(input logic [BYTE_W-1:0] hdr);
      csrc_end = RTP_FIXED_LEN + {1'b0, hdr[3:0], 2'b00};
   endfunction

endpackage

[src/rtpsbc_in_stage.sv]
// Input register of the payload locator: holds one request beat.
module rtpsbc_in_stage (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [rtpsbc_pkg::BYTE_W-1:0] req_data_byte,
   input  logic                          req_last_byte,
   input  logic                          advance,
   output logic                          beat_valid,
   output logic [rtpsbc_pkg::BYTE_W-1:0] beat_data,
   output logic                          beat_last
);

   logic                          valid_ff;
   logic [rtpsbc_pkg::BYTE_W-1:0] data_ff;
   logic                          last_ff;

   // The register frees up in the same cycle its beat moves on.
   assign req_ready = !valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_ready) begin
         valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         data_ff <= req_data_byte;
         last_ff <= req_last_byte;
      end
   end

   assign beat_valid = valid_ff;
   assign beat_data  = data_ff;
   assign beat_last  = last_ff;

endmodule

[src/rtpsbc_tracker.sv]
// Per-packet header tracking: byte count, extension length and media header capture.
module rtpsbc_tracker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          fire,
   input  logic [rtpsbc_pkg::BYTE_W-1:0] data,
   input  logic                          last,
   output rtpsbc_pkg::pkt_view_type      view
);

   logic [rtpsbc_pkg::COUNT_W-1:0] count_ff,  count_in;
   logic                           over_ff,   over_in;
   logic [rtpsbc_pkg::BYTE_W-1:0]  hfb_ff,    hfb_in;
   logic [rtpsbc_pkg::EXT_W-1:0]   ewc_ff,    ewc_in;
   logic [rtpsbc_pkg::POS_W-1:0]   mhp_ff,    mhp_in;
   logic [rtpsbc_pkg::BYTE_W-1:0]  mhb_ff,    mhb_in;
   logic [rtpsbc_pkg::BASE_W-1:0]  base_old;
   logic [rtpsbc_pkg::BASE_W-1:0]  base_new;

   assign base_old = rtpsbc_pkg::csrc_end(hfb_ff);
   assign base_new = rtpsbc_pkg::csrc_end(data);

   always_comb begin
      hfb_in = hfb_ff;
      ewc_in = ewc_ff;
      mhp_in = mhp_ff;
      mhb_in = mhb_ff;

      if (!over_ff) begin
         if (count_ff == '0) begin
            hfb_in = data;
            ewc_in = '0;
            // Until the word count is read, the media header sits right after
            // the extension header, so nothing is captured too early.
            mhp_in = {{(rtpsbc_pkg::POS_W-rtpsbc_pkg::BASE_W){1'b0}}, base_new}
                     + (data[rtpsbc_pkg::HDR_EXT_BIT] ? rtpsbc_pkg::EXT_HDR_LEN : '0);
         end else if (hfb_ff[rtpsbc_pkg::HDR_EXT_BIT]) begin
            if (count_ff == {9'b0, base_old} + 16'd2) begin
               ewc_in = {data, ewc_ff[7:0]};
            end else if (count_ff == {9'b0, base_old} + 16'd3) begin
               ewc_in = {ewc_ff[15:8], data};
               mhp_in = {{(rtpsbc_pkg::POS_W-rtpsbc_pkg::BASE_W){1'b0}}, base_old}
                        + rtpsbc_pkg::EXT_HDR_LEN + {1'b0, ewc_in, 2'b00};
            end
         end
         if ({3'b0, count_ff} == mhp_in) begin
            mhb_in = data;
         end
      end
   end

   assign view.byte_index   = count_ff;
   assign view.overlength   = over_ff;
   assign view.header_first = hfb_in;
   assign view.media_pos    = mhp_in;
   assign view.media_hdr    = mhb_in;

   always_comb begin
      count_in = count_ff;
      over_in  = over_ff;
      if (last) begin
         count_in = '0;
         over_in  = 1'b0;
      end else if (count_ff == '1) begin
         over_in = 1'b1;
      end else begin
         count_in = count_ff + 16'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         over_ff  <= 1'b0;
         hfb_ff   <= '0;
         ewc_ff   <= '0;
         mhp_ff   <= '0;
         mhb_ff   <= '0;
      end else if (fire) begin
         count_ff <= count_in;
         over_ff  <= over_in;
         if (last) begin
            hfb_ff <= '0;
            ewc_ff <= '0;
            mhp_ff <= '0;
            mhb_ff <= '0;
         end else begin
            hfb_ff <= hfb_in;
            ewc_ff <= ewc_in;
            mhp_ff <= mhp_in;
            mhb_ff <= mhb_in;
         end
      end
   end

endmodule

[src/rtpsbc_checker.sv]
// End-of-packet checks and the result register.
module rtpsbc_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            load,
   input  logic [rtpsbc_pkg::BYTE_W-1:0]   data,
   input  rtpsbc_pkg::pkt_view_type        view,
   output logic                            out_free,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_accepted,
   output logic [rtpsbc_pkg::CODE_W-1:0]   rsp_error_code,
   output logic [rtpsbc_pkg::COUNT_W-1:0]  rsp_payload_offset,
   output logic [rtpsbc_pkg::COUNT_W-1:0]  rsp_payload_length,
   output logic [rtpsbc_pkg::FRAMES_W-1:0] rsp_frame_count
);

   logic [rtpsbc_pkg::SIZE_W-1:0]   size;
   logic [rtpsbc_pkg::POS_W-1:0]    size_w;
   logic [rtpsbc_pkg::POS_W-1:0]    base_w;
   logic [rtpsbc_pkg::POS_W-1:0]    pos;
   logic [rtpsbc_pkg::POS_W-1:0]    rem;
   logic [rtpsbc_pkg::POS_W-1:0]    ext_room;
   logic [rtpsbc_pkg::POS_W-1:0]    data_w;
   logic [rtpsbc_pkg::POS_W-1:0]    span;
   logic                            has_ext;
   logic                            has_pad;
   rtpsbc_pkg::err_code_type        code;

   logic                            valid_ff;
   rtpsbc_pkg::err_code_type        code_ff;
   logic [rtpsbc_pkg::COUNT_W-1:0]  offset_ff;
   logic [rtpsbc_pkg::COUNT_W-1:0]  length_ff;
   logic [rtpsbc_pkg::FRAMES_W-1:0] frames_ff;

   assign has_ext  = view.header_first[rtpsbc_pkg::HDR_EXT_BIT];
   assign has_pad  = view.header_first[rtpsbc_pkg::HDR_PAD_BIT];
   assign size     = {1'b0, view.byte_index} + 17'd1;
   assign size_w   = {2'b0, size};
   assign base_w   = {12'b0, rtpsbc_pkg::csrc_end(view.header_first)};
   assign pos      = has_ext ? view.media_pos : base_w;
   assign rem      = size_w - pos;
   assign ext_room = size_w - base_w;
   assign data_w   = {11'b0, data};
   // Bytes from the media header to the end of the payload, padding removed.
   assign span     = has_pad ? rem - data_w : rem;

   always_comb begin
      if (view.overlength || view.byte_index == '1) begin
         code = rtpsbc_pkg::ERR_TOO_LONG;
      end else if (size < rtpsbc_pkg::RTP_MIN_LEN) begin
         code = rtpsbc_pkg::ERR_SHORT;
      end else if (view.header_first[7:6] != rtpsbc_pkg::HDR_VER_EXPECTED) begin
         code = rtpsbc_pkg::ERR_VERSION;
      end else if (base_w > size_w) begin
         code = rtpsbc_pkg::ERR_CSRC_OVERRUN;
      end else if (has_ext && ext_room < rtpsbc_pkg::EXT_HDR_LEN) begin
         code = rtpsbc_pkg::ERR_EXT_TRUNCATED;
      end else if (has_ext && view.media_pos > size_w) begin
         code = rtpsbc_pkg::ERR_EXT_OVERRUN;
      end else if (has_pad && (data == '0 || data_w > rem)) begin
         code = rtpsbc_pkg::ERR_PADDING;
      end else if (span == '0) begin
         code = rtpsbc_pkg::ERR_NO_SBC_HEADER;
      end else if (view.media_hdr[3:0] == '0) begin
         code = rtpsbc_pkg::ERR_ZERO_FRAMES;
      end else if (span == 19'd1) begin
         code = rtpsbc_pkg::ERR_EMPTY_PAYLOAD;
      end else begin
         code = rtpsbc_pkg::ERR_NONE;
      end
   end

   assign out_free = !valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         code_ff <= code;
         if (code == rtpsbc_pkg::ERR_NONE) begin
            offset_ff <= 16'(pos + 19'd1);
            length_ff <= 16'(span - 19'd1);
            frames_ff <= view.media_hdr[3:0];
         end else begin
            offset_ff <= '0;
            length_ff <= '0;
            frames_ff <= '0;
         end
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_accepted       = (code_ff == rtpsbc_pkg::ERR_NONE);
   assign rsp_error_code     = code_ff;
   assign rsp_payload_offset = offset_ff;
   assign rsp_payload_length = length_ff;
   assign rsp_frame_count    = frames_ff;

endmodule

[src/rtp_sbc_payload_locator.sv]
// Top level of the RTP / A2DP SBC payload locator.
//
// The req channel carries one packet byte per beat, in arrival order, with
// req_last_byte set on the final byte. The rsp channel carries one beat per
// packet: accepted, the error code, the SBC payload offset and length, and
// the frame count from the media header byte. Non-final bytes give no beat.
//
// A byte is held in the input register, then applied to the header tracker;
// on the final byte the checks run in the same cycle and the result lands in
// the output register. The result beat is valid once the final byte has passed
// the input register and its result is in the output register. One byte is
// taken every cycle unless a final byte waits in the input register for room.
//
// Reset clears the byte count, the captured header state and both beat
// registers. When the receiver stalls, the final byte of the next packet
// waits in the input register until the pending result is taken; earlier
// bytes of that packet keep flowing into the tracker.
module rtp_sbc_payload_locator (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [rtpsbc_pkg::BYTE_W-1:0]   req_data_byte,
   input  logic                            req_last_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_accepted,
   output logic [rtpsbc_pkg::CODE_W-1:0]   rsp_error_code,
   output logic [rtpsbc_pkg::COUNT_W-1:0]  rsp_payload_offset,
   output logic [rtpsbc_pkg::COUNT_W-1:0]  rsp_payload_length,
   output logic [rtpsbc_pkg::FRAMES_W-1:0] rsp_frame_count
);

   logic                          beat_valid;
   logic [rtpsbc_pkg::BYTE_W-1:0] beat_data;
   logic                          beat_last;
   logic                          advance;
   logic                          out_free;
   rtpsbc_pkg::pkt_view_type      view;

   // Only a final byte needs room in the result register.
   assign advance = beat_valid && (!beat_last || out_free);

   rtpsbc_in_stage u_in_stage (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .advance       (advance),
      .beat_valid    (beat_valid),
      .beat_data     (beat_data),
      .beat_last     (beat_last)
   );

   rtpsbc_tracker u_tracker (
      .clock (clock),
      .reset (reset),
      .fire  (advance),
      .data  (beat_data),
      .last  (beat_last),
      .view  (view)
   );

   rtpsbc_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .load               (advance && beat_last),
      .data               (beat_data),
      .view               (view),
      .out_free           (out_free),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_accepted       (rsp_accepted),
      .rsp_error_code     (rsp_error_code),
      .rsp_payload_offset (rsp_payload_offset),
      .rsp_payload_length (rsp_payload_length),
      .rsp_frame_count    (rsp_frame_count)
   );

endmodule

[tb/sv/tb_rtp_sbc_payload_locator.sv]
// Self-checking testbench for the RTP / A2DP SBC payload locator.
module tb_rtp_sbc_payload_locator;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 3_000_000;
   localparam int IDLE_PCT     = 22;
   localparam int RANDOM_BYTES = 800;
   localparam int RANDOM_PKTS  = 48;

   typedef struct packed {
      logic                            accepted;
      rtpsbc_pkg::err_code_type        code;
      logic [rtpsbc_pkg::COUNT_W-1:0]  offset;
      logic [rtpsbc_pkg::COUNT_W-1:0]  length;
      logic [rtpsbc_pkg::FRAMES_W-1:0] frames;
   } locator_result_type;

   // One packet to send. total_len cuts or fills the packet to that size when
   // positive; tail forces the final byte when not negative.
   typedef struct {
      logic [7:0]                      hdr0;
      logic [15:0]                     ext_words;
      logic [7:0]                      media;
      int                              payload_len;
      int                              pad_len;
      int                              total_len;
      int                              tail;
      bit                              typed;
      rtpsbc_pkg::err_code_type        exp_code;
      logic [rtpsbc_pkg::COUNT_W-1:0]  exp_offset;
      logic [rtpsbc_pkg::COUNT_W-1:0]  exp_length;
      logic [rtpsbc_pkg::FRAMES_W-1:0] exp_frames;
   } pkt_spec_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic [rtpsbc_pkg::BYTE_W-1:0]   req_data_byte = '0;
   logic                            req_last_byte = 1'b0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic                            rsp_accepted;
   logic [rtpsbc_pkg::CODE_W-1:0]   rsp_error_code;
   logic [rtpsbc_pkg::COUNT_W-1:0]  rsp_payload_offset;
   logic [rtpsbc_pkg::COUNT_W-1:0]  rsp_payload_length;
   logic [rtpsbc_pkg::FRAMES_W-1:0] rsp_frame_count;

   rtp_sbc_payload_locator u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_last_byte      (req_last_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_accepted       (rsp_accepted),
      .rsp_error_code     (rsp_error_code),
      .rsp_payload_offset (rsp_payload_offset),
      .rsp_payload_length (rsp_payload_length),
      .rsp_frame_count    (rsp_frame_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state, cleared after every packet.
   logic [rtpsbc_pkg::COUNT_W-1:0] trk_count = '0;
   logic [rtpsbc_pkg::BYTE_W-1:0]  trk_hdr0 = '0;
   logic [rtpsbc_pkg::EXT_W-1:0]   trk_ext = '0;
   logic [rtpsbc_pkg::POS_W-1:0]   trk_media_pos = '0;
   logic [rtpsbc_pkg::BYTE_W-1:0]  trk_media = '0;
   logic                           trk_over = 1'b0;

   locator_result_type pending_results[$];
   pkt_spec_type       directed_pkts[$];
   int                 mismatches = 0;
   int                 cycles = 0;
   bit                 steady = 1'b0;

   task automatic locate_step(input logic [7:0] d, input logic last,
                              output logic done, output locator_result_type r);
      int unsigned i, base, size, pos, stop, hfb;
      rtpsbc_pkg::err_code_type code;
      i = trk_count;
      code = rtpsbc_pkg::ERR_NONE;
      r = '0;
      done = last;
      if (!trk_over) begin
         if (i == 0) begin
            trk_hdr0 = d;
            trk_ext = '0;
            trk_media_pos = 19'(12 + 4 * int'(d[3:0]) + (d[4] ? 4 : 0));
         end else if (trk_hdr0[4]) begin
            base = 12 + 4 * int'(trk_hdr0[3:0]);
            if (i == base + 2) begin
               trk_ext = {d, trk_ext[7:0]};
            end else if (i == base + 3) begin
               trk_ext = {trk_ext[15:8], d};
               trk_media_pos = 19'(base + 4 + 4 * int'(trk_ext));
            end
         end
         if (i == trk_media_pos) trk_media = d;
      end
      if (!last) begin
         if (trk_count == 16'hffff) trk_over = 1'b1;
         else trk_count = trk_count + 1'b1;
      end else begin
         if (trk_over || i == 32'hffff) begin
            code = rtpsbc_pkg::ERR_TOO_LONG;
         end else begin
            size = i + 1;
            hfb = trk_hdr0;
            pos = 12 + 4 * (hfb & 32'h0f);
            stop = size;
            if (size < 13) code = rtpsbc_pkg::ERR_SHORT;
            else if ((hfb >> 6) != 2) code = rtpsbc_pkg::ERR_VERSION;
            else if (pos > size) code = rtpsbc_pkg::ERR_CSRC_OVERRUN;
            else begin
               if (hfb[4]) begin
                  if (size - pos < 4) code = rtpsbc_pkg::ERR_EXT_TRUNCATED;
                  else begin
                     pos = trk_media_pos;
                     if (pos > size) code = rtpsbc_pkg::ERR_EXT_OVERRUN;
                  end
               end
               if (code == rtpsbc_pkg::ERR_NONE && hfb[5]) begin
                  if (d == 0 || d > stop - pos) code = rtpsbc_pkg::ERR_PADDING;
                  else stop = stop - d;
               end
               if (code == rtpsbc_pkg::ERR_NONE && stop - pos < 1)
                  code = rtpsbc_pkg::ERR_NO_SBC_HEADER;
               if (code == rtpsbc_pkg::ERR_NONE && trk_media[3:0] == 0)
                  code = rtpsbc_pkg::ERR_ZERO_FRAMES;
               if (code == rtpsbc_pkg::ERR_NONE && pos + 1 >= stop)
                  code = rtpsbc_pkg::ERR_EMPTY_PAYLOAD;
               if (code == rtpsbc_pkg::ERR_NONE) begin
                  r.frames = trk_media[3:0];
                  r.offset = 16'(pos + 1);
                  r.length = 16'(stop - pos - 1);
               end
            end
         end
         r.code = code;
         r.accepted = (code == rtpsbc_pkg::ERR_NONE);
         trk_count = '0;
         trk_hdr0 = '0;
         trk_ext = '0;
         trk_media_pos = '0;
         trk_media = '0;
         trk_over = 1'b0;
      end
   endtask

   task automatic build_packet(input pkt_spec_type s, ref logic [7:0] q[$]);
      int cap;
      cap = (s.total_len > 0) ? s.total_len : 32'h7fff_ffff;
      q.delete();
      q.push_back(s.hdr0);
      for (int k = 0; k < 11 + 4 * int'(s.hdr0[3:0]); k++) q.push_back(8'($urandom));
      if (s.hdr0[4]) begin
         q.push_back(8'($urandom));
         q.push_back(8'($urandom));
         q.push_back(s.ext_words[15:8]);
         q.push_back(s.ext_words[7:0]);
         for (int k = 0; k < 4 * int'(s.ext_words) && q.size() < cap; k++)
            q.push_back(8'($urandom));
      end
      q.push_back(s.media);
      for (int k = 0; k < s.payload_len; k++) q.push_back(8'($urandom));
      if (s.pad_len > 0) begin
         for (int k = 1; k < s.pad_len; k++) q.push_back(8'($urandom));
         q.push_back(8'(s.pad_len));
      end
      if (s.total_len > 0) begin
         while (q.size() > s.total_len) void'(q.pop_back());
         while (q.size() < s.total_len) q.push_back(8'($urandom));
      end
      if (s.tail >= 0) q[q.size() - 1] = 8'(s.tail);
   endtask

   // Returns in the time step of the accepting edge.
   task automatic push_byte(input logic [7:0] d, input logic last);
      @(negedge clock);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data_byte = d;
      req_last_byte = last;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_packet(input pkt_spec_type s, output int n_bytes);
      logic [7:0]         pkt[$];
      logic               done;
      locator_result_type r, typed_r;
      build_packet(s, pkt);
      n_bytes = pkt.size();
      typed_r.accepted = (s.exp_code == rtpsbc_pkg::ERR_NONE);
      typed_r.code = s.exp_code;
      typed_r.offset = s.exp_offset;
      typed_r.length = s.exp_length;
      typed_r.frames = s.exp_frames;
      foreach (pkt[k]) begin
         push_byte(pkt[k], k == pkt.size() - 1);
         locate_step(pkt[k], k == pkt.size() - 1, done, r);
         if (done) pending_results.push_back(s.typed ? typed_r : r);
      end
   endtask

   function automatic void add_row(input logic [7:0] hdr0, input logic [15:0] ext,
                                   input logic [7:0] media, input int pay, input int pad,
                                   input int total, input int tail, input bit typed,
                                   input rtpsbc_pkg::err_code_type code,
                                   input int off = 0, input int len = 0,
                                   input int fr = 0);
      pkt_spec_type s;
      s.hdr0 = hdr0;
      s.ext_words = ext;
      s.media = media;
      s.payload_len = pay;
      s.pad_len = pad;
      s.total_len = total;
      s.tail = tail;
      s.typed = typed;
      s.exp_code = code;
      s.exp_offset = 16'(off);
      s.exp_length = 16'(len);
      s.exp_frames = 4'(fr);
      directed_pkts.push_back(s);
   endfunction

   function automatic pkt_spec_type random_packet();
      pkt_spec_type s;
      int           kind, cc;
      logic         p, x;
      kind = $urandom_range(99);
      cc = ($urandom_range(7) == 0) ? $urandom_range(15) : $urandom_range(2);
      p = 1'($urandom_range(1));
      x = ($urandom_range(2) == 0);
      s.hdr0 = {rtpsbc_pkg::HDR_VER_EXPECTED, p, x, 4'(cc)};
      if (!x) s.ext_words = '0;
      else if ($urandom_range(9) == 0) s.ext_words = 16'($urandom_range(40));
      else s.ext_words = 16'($urandom_range(3));
      s.media = {4'($urandom_range(15)),
                 ($urandom_range(11) == 0) ? 4'h0 : 4'($urandom_range(15, 1))};
      s.payload_len = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(40);
      s.pad_len = p ? $urandom_range(6, 1) : 0;
      s.total_len = 0;
      s.tail = -1;
      s.typed = 1'b0;
      s.exp_code = rtpsbc_pkg::ERR_NONE;
      s.exp_offset = '0;
      s.exp_length = '0;
      s.exp_frames = '0;
      if (kind >= 90) begin
         // Plain noise: random header byte and a short random length.
         s.hdr0 = 8'($urandom);
         s.ext_words = 16'($urandom);
         s.total_len = $urandom_range(40, 1);
      end else if (kind >= 70) begin
         case ($urandom_range(3))
            0: s.total_len = $urandom_range(48, 1);
            1: s.tail = $urandom_range(255);
            2: s.hdr0[7:6] = 2'($urandom_range(3));
            default: begin
               s.hdr0[4] = 1'b1;
               s.ext_words = 16'($urandom);
               s.total_len = $urandom_range(80, 13);
            end
         endcase
      end
      return s;
   endfunction

   always @(negedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
   end

   always @(posedge clock) begin
      locator_result_type want;
      bit bad;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected beat acc=%0d code=%0d off=%0d len=%0d fr=%0d",
                        rsp_accepted, rsp_error_code, rsp_payload_offset,
                        rsp_payload_length, rsp_frame_count);
         end else begin
            want = pending_results.pop_front();
            bad = (rsp_accepted !== want.accepted) || (rsp_error_code !== want.code)
               || (rsp_payload_offset !== want.offset)
               || (rsp_payload_length !== want.length)
               || (rsp_frame_count !== want.frames);
            if (bad) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("ERROR: acc/code/off/len/fr exp %0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d",
                           want.accepted, want.code, want.offset, want.length,
                           want.frames, rsp_accepted, rsp_error_code,
                           rsp_payload_offset, rsp_payload_length, rsp_frame_count);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("rtp_sbc_payload_locator verification failed");
         $finish;
      end
   end

   initial begin
      int n, rand_bytes, rand_pkts;
      rand_bytes = 0;
      rand_pkts = 0;

      // Typed rows: results that follow directly from the header rules.
      add_row(8'h80, 16'h0, 8'h01, 1, 0, 0, -1, 1, rtpsbc_pkg::ERR_NONE, 13, 1, 1);
      add_row(8'h80, 16'h0, 8'h01, 4, 0, 1, -1, 1, rtpsbc_pkg::ERR_SHORT);
      add_row(8'h80, 16'h0, 8'h01, 4, 0, 12, -1, 1, rtpsbc_pkg::ERR_SHORT);
      add_row(8'h00, 16'h0, 8'h11, 4, 0, 0, -1, 1, rtpsbc_pkg::ERR_VERSION);
      add_row(8'hC0, 16'h0, 8'h11, 4, 0, 0, -1, 1, rtpsbc_pkg::ERR_VERSION);
      add_row(8'h40, 16'h0, 8'h11, 4, 0, 0, -1, 1, rtpsbc_pkg::ERR_VERSION);
      add_row(8'h8F, 16'h0, 8'h11, 4, 0, 20, -1, 1, rtpsbc_pkg::ERR_CSRC_OVERRUN);
      add_row(8'h90, 16'h0, 8'h11, 4, 0, 14, -1, 1, rtpsbc_pkg::ERR_EXT_TRUNCATED);
      add_row(8'h90, 16'hFFFF, 8'h11, 8, 0, 40, -1, 1, rtpsbc_pkg::ERR_EXT_OVERRUN);
      add_row(8'hA0, 16'h0, 8'h01, 4, 0, 0, 0, 1, rtpsbc_pkg::ERR_PADDING);
      add_row(8'hA0, 16'h0, 8'h01, 4, 0, 0, 255, 1, rtpsbc_pkg::ERR_PADDING);
      add_row(8'h81, 16'h0, 8'h01, 4, 0, 16, -1, 1, rtpsbc_pkg::ERR_NO_SBC_HEADER);
      add_row(8'h80, 16'h0, 8'hF0, 4, 0, 0, -1, 1, rtpsbc_pkg::ERR_ZERO_FRAMES);
      add_row(8'h80, 16'h0, 8'h05, 0, 0, 0, -1, 1, rtpsbc_pkg::ERR_EMPTY_PAYLOAD);
      // Rows left to the predictor.
      add_row(8'h90, 16'h0002, 8'h23, 10, 0, 0, -1, 0, rtpsbc_pkg::ERR_NONE);
      add_row(8'h90, 16'h0000, 8'h08, 2, 0, 0, -1, 0, rtpsbc_pkg::ERR_NONE);
      add_row(8'h90, 16'h0101, 8'h47, 5, 0, 0, -1, 0, rtpsbc_pkg::ERR_NONE);
      add_row(8'hBF, 16'h0003, 8'hFF, 20, 3, 0, -1, 0, rtpsbc_pkg::ERR_NONE);
      add_row(8'hA0, 16'h0, 8'h02, 0, 1, 0, -1, 0, rtpsbc_pkg::ERR_NONE);
      add_row(8'h3F, 16'h0, 8'h02, 6, 2, 0, -1, 0, rtpsbc_pkg::ERR_NONE);
      // Largest legal packet, then one and two bytes past it.
      add_row(8'h80, 16'h0, 8'h0F, 65522, 0, 0, -1, 1, rtpsbc_pkg::ERR_NONE,
              13, 65522, 15);
      add_row(8'h80, 16'h0, 8'h0F, 65523, 0, 0, -1, 1, rtpsbc_pkg::ERR_TOO_LONG);
      add_row(8'h80, 16'h0, 8'h0F, 65524, 0, 0, -1, 1, rtpsbc_pkg::ERR_TOO_LONG);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_pkts[k]) send_packet(directed_pkts[k], n);

      while (rand_bytes < RANDOM_BYTES || rand_pkts < RANDOM_PKTS) begin
         // A stretch of packets with both sides running flat out.
         steady = (rand_pkts >= 12 && rand_pkts < 28);
         send_packet(random_packet(), n);
         rand_bytes += n;
         rand_pkts++;
      end
      steady = 1'b0;

      @(negedge clock);
      req_valid = 1'b0;
      req_last_byte = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("rtp_sbc_payload_locator verification clean");
      end else begin
         $display("rtp_sbc_payload_locator verification failed");
      end
      $finish;
   end

endmodule
